// ===== rtl/core/cde_pkg.sv =====
// ---------------------------------------------------------------------------
// cde_pkg
// Shared types, character constants and helper functions for the dirty-cell
// terminal update encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package cde_pkg;

	// Default screen size and queue depth.
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 128;
	localparam int QUEUE_DEPTH  = 4;

	// Characters of the escape sequences.
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_M      = 8'h6D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_THREE  = 8'h33;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// A decimal number of up to three digits; nd is the digit count (1 to 3).
	typedef struct packed {
		logic [1:0] h;
		logic [3:0] t;
		logic [3:0] o;
		logic [1:0] nd;
	} dec_t;

	// One queued request for the byte sequencer.
	typedef struct packed {
		logic       do_move;
		logic       do_color;
		logic       do_glyph;
		logic       do_reset;
		dec_t       row_d;
		dec_t       col_d;
		logic [3:0] color;
		logic [7:0] glyph;
	} cmd_t;

	// Byte slots of the output template, in emission order.
	typedef enum logic [4:0] {
		P_MV_ESC,
		P_MV_LB,
		P_ROW_H,
		P_ROW_T,
		P_ROW_O,
		P_SEMI,
		P_COL_H,
		P_COL_T,
		P_COL_O,
		P_MV_H,
		P_CL_ESC,
		P_CL_LB,
		P_CL_BANK,
		P_CL_DIG,
		P_CL_M,
		P_GLYPH,
		P_RS_ESC,
		P_RS_LB,
		P_RS_ZERO,
		P_RS_M
	} seq_pos_t;

	localparam int NUM_POS = 20;

	typedef struct packed {
		logic     found;
		seq_pos_t pos;
	} pos_pick_t;

	// Split a value below 256 into decimal digits. The tens digit of the
	// remainder (below 100) comes from a multiply by 205 and a shift by 11.
	function automatic dec_t to_dec(input logic [7:0] v);
		dec_t        d;
		logic [7:0]  r;
		logic [15:0] p;
		logic [7:0]  o8;
		if (v >= 8'd200) begin
			d.h = 2'd2;
			r   = v - 8'd200;
		end else if (v >= 8'd100) begin
			d.h = 2'd1;
			r   = v - 8'd100;
		end else begin
			d.h = 2'd0;
			r   = v;
		end
		p   = {8'b0, r} * 16'd205;
		d.t = p[14:11];
		o8  = r - ({4'b0, d.t} * 8'd10);
		d.o = o8[3:0];
		if (v >= 8'd100) begin
			d.nd = 2'd3;
		end else if (v >= 8'd10) begin
			d.nd = 2'd2;
		end else begin
			d.nd = 2'd1;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cell_diff_ansi_encoder.sv =====
// ---------------------------------------------------------------------------
// cell_diff_ansi_encoder
// Dirty-cell encoder that turns a stream of text-screen cells into a
// terminal update byte stream with cursor moves and color escapes.
// ---------------------------------------------------------------------------
// After reset the block sweeps its shown-frame store to zero, one entry per
// cycle, over all MAX_ROWS*MAX_COLS entries (8192 with the defaults); s_tready
// stays low during that pass. Afterwards a cell that matches the store, or lies
// off the screen, queues nothing unless it ends a frame that sent bytes; the
// store has a single read port. A changed cell or such a frame end queues a
// request, and the sequencer sends one byte per cycle while the output is not
// stalled, from 1 up to 19 bytes per cell; a four-entry request queue lets
// cells keep arriving while earlier bytes drain, so over a long stretch the
// rate is one cell per cycle or one output byte per cycle, whichever is slower.
`default_nettype none

module cell_diff_ansi_encoder import cde_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // row[5:0], col[12:6], glyph[20:13], color[24:21], zero
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast    // last_of_item
);

	logic q_push;
	cmd_t q_wr_data;
	logic q_full;
	logic q_pop;
	cmd_t q_rd_data;
	logic q_not_empty;

	// Classifying front with the shown-frame store.
	cde_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.row      (s_tdata[5:0]),
		.col      (s_tdata[12:6]),
		.glyph    (s_tdata[20:13]),
		.color    (s_tdata[24:21]),
		.frame_end(s_tlast),
		.q_push   (q_push),
		.q_data   (q_wr_data),
		.q_full   (q_full)
	);

	// Request queue.
	cde_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wr_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_rd_data),
		.not_empty(q_not_empty)
	);

	// Byte sequencer and output register.
	cde_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_data  (q_rd_data),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/core/cde_fifo.sv =====
// ---------------------------------------------------------------------------
// cde_fifo
// Small request queue between the classifying front and the byte sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module cde_fifo import cde_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == (PTR_W + 1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cde_front.sv =====
// ---------------------------------------------------------------------------
// cde_front
// Accepts cells, compares them against the shown-frame store, updates the
// store and the run and color state, and queues a request per changed cell or frame reset.
// ---------------------------------------------------------------------------
`default_nettype none

module cde_front import cde_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [5:0] row,
	input  logic [6:0] col,
	input  logic [7:0] glyph,
	input  logic [3:0] color,
	input  logic       frame_end,
	output logic       q_push,
	output cmd_t       q_data,
	input  logic       q_full
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Store entry: glyph in the upper byte, color in the low nibble.
	logic [11:0]       mem [DEPTH];

	logic              clearing_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic              s1_valid_q;
	logic [5:0]        row_s1;
	logic [6:0]        col_s1;
	logic [7:0]        glyph_s1;
	logic [3:0]        color_s1;
	logic              last_s1;
	logic              pos_ok_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [11:0]       rd_s1;
	logic              fwd_hit_s1;
	logic [11:0]       fwd_data_s1;

	logic              run_open_q;
	logic [3:0]        emit_color_q;
	logic              emit_color_vld_q;
	logic              frame_out_q;

	logic              accept;
	logic              advance;
	logic              in_pos_ok;
	logic [ADDR_W-1:0] in_idx;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [11:0]       wr_data;
	logic              upd_wr;
	logic [11:0]       cur;
	logic              run_eff;
	logic              changed;
	logic              do_move;
	logic              do_color;
	logic              do_reset;

	// Input handshake: closed during the clearing pass and while stage one is stuck.
	assign advance  = s1_valid_q && !q_full;
	assign s_tready = !clearing_q && (!s1_valid_q || !q_full);
	assign accept   = s_tvalid && s_tready;

	// Store address of the incoming cell; off-screen cells never write the store.
	assign in_pos_ok = (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);
	assign in_idx    = in_pos_ok ? ADDR_W'(int'(row) * MAX_COLS + int'(col)) : '0;

	// Single write port, shared by the clearing pass and cell updates.
	assign wr_en   = clearing_q || upd_wr;
	assign wr_addr = clearing_q ? clr_cnt_q : idx_s1;
	assign wr_data = clearing_q ? 12'd0 : {glyph_s1, color_s1};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			rd_s1 <= mem[in_idx];
		end
	end

	// Stage one payload, including a bypass for a write in the same cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1      <= row;
			col_s1      <= col;
			glyph_s1    <= glyph;
			color_s1    <= color;
			last_s1     <= frame_end;
			pos_ok_s1   <= in_pos_ok;
			idx_s1      <= in_idx;
			fwd_hit_s1  <= upd_wr && (idx_s1 == in_idx);
			fwd_data_s1 <= {glyph_s1, color_s1};
		end
	end

	// Classify the cell in stage one.
	always_comb begin
		cur      = fwd_hit_s1 ? fwd_data_s1 : rd_s1;
		run_eff  = (col_s1 == 7'd0) ? 1'b0 : run_open_q;
		changed  = pos_ok_s1 && (cur != {glyph_s1, color_s1});
		do_move  = changed && !run_eff;
		do_color = changed && (!emit_color_vld_q || (emit_color_q != color_s1));
		do_reset = last_s1 && (frame_out_q || changed);
		upd_wr   = advance && changed;
		q_push   = advance && (changed || do_reset);
	end

	// Request for the sequencer.
	always_comb begin
		q_data.do_move  = do_move;
		q_data.do_color = do_color;
		q_data.do_glyph = changed;
		q_data.do_reset = do_reset;
		q_data.row_d    = to_dec({2'b0, row_s1} + 8'd1);
		q_data.col_d    = to_dec({1'b0, col_s1} + 8'd1);
		q_data.color    = color_s1;
		q_data.glyph    = glyph_s1;
	end

	// Control state: clearing pass, stage valid, run and color tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q       <= 1'b1;
			clr_cnt_q        <= '0;
			s1_valid_q       <= 1'b0;
			run_open_q       <= 1'b0;
			emit_color_q     <= 4'd0;
			emit_color_vld_q <= 1'b0;
			frame_out_q      <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				run_open_q <= changed && !last_s1;
				if (do_color) begin
					emit_color_q <= color_s1;
				end
				emit_color_vld_q <= !last_s1 && (emit_color_vld_q || do_color);
				frame_out_q      <= !last_s1 && (frame_out_q || changed);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cde_back.sv =====
// ---------------------------------------------------------------------------
// cde_back
// Byte sequencer: walks the enabled slots of the escape template for each
// queued request and drives the output stream through a holding register.
// ---------------------------------------------------------------------------
`default_nettype none

module cde_back import cde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_data,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic         active_q;
	seq_pos_t     pos_q;
	cmd_t         cmd_q;
	logic         out_vld_q;
	logic [7:0]   byte_q;
	logic         last_q;

	logic         active_d;
	seq_pos_t     pos_d;
	logic         out_free;
	logic         emit;
	logic [NUM_POS-1:0] cur_en;
	logic [NUM_POS-1:0] above;
	pos_pick_t    nxt;
	pos_pick_t    first;
	logic [7:0]   byte_d;

	// Which template slots a request fills.
	function automatic logic [NUM_POS-1:0] build_en(input cmd_t c);
		logic [NUM_POS-1:0] e;
		e            = '0;
		e[P_MV_ESC]  = c.do_move;
		e[P_MV_LB]   = c.do_move;
		e[P_ROW_H]   = c.do_move && (c.row_d.nd == 2'd3);
		e[P_ROW_T]   = c.do_move && (c.row_d.nd != 2'd1);
		e[P_ROW_O]   = c.do_move;
		e[P_SEMI]    = c.do_move;
		e[P_COL_H]   = c.do_move && (c.col_d.nd == 2'd3);
		e[P_COL_T]   = c.do_move && (c.col_d.nd != 2'd1);
		e[P_COL_O]   = c.do_move;
		e[P_MV_H]    = c.do_move;
		e[P_CL_ESC]  = c.do_color;
		e[P_CL_LB]   = c.do_color;
		e[P_CL_BANK] = c.do_color;
		e[P_CL_DIG]  = c.do_color;
		e[P_CL_M]    = c.do_color;
		e[P_GLYPH]   = c.do_glyph;
		e[P_RS_ESC]  = c.do_reset;
		e[P_RS_LB]   = c.do_reset;
		e[P_RS_ZERO] = c.do_reset;
		e[P_RS_M]    = c.do_reset;
		return e;
	endfunction

	// Lowest set slot of a mask.
	function automatic pos_pick_t first_set(input logic [NUM_POS-1:0] v);
		pos_pick_t r;
		r.found = 1'b0;
		r.pos   = P_MV_ESC;
		for (int i = NUM_POS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.found = 1'b1;
				r.pos   = seq_pos_t'(5'(i));
			end
		end
		return r;
	endfunction

	// Slots after the current one.
	always_comb begin
		cur_en = build_en(cmd_q);
		for (int i = 0; i < NUM_POS; i++) begin
			above[i] = cur_en[i] && (5'(i) > pos_q);
		end
		nxt   = first_set(above);
		first = first_set(build_en(q_data));
	end

	assign out_free = !out_vld_q || m_tready;
	assign emit     = active_q && out_free;
	assign q_pop    = q_valid && (!active_q || (emit && !nxt.found));

	// Next state of the sequencer.
	always_comb begin
		active_d = active_q;
		pos_d    = pos_q;
		if (q_pop) begin
			active_d = 1'b1;
			pos_d    = first.pos;
		end else if (emit) begin
			active_d = nxt.found;
			pos_d    = nxt.pos;
		end
	end

	// Byte for the current slot.
	always_comb begin
		case (pos_q)
			P_MV_ESC:  byte_d = CH_ESC;
			P_MV_LB:   byte_d = CH_LBRACK;
			P_ROW_H:   byte_d = CH_ZERO + {6'b0, cmd_q.row_d.h};
			P_ROW_T:   byte_d = CH_ZERO + {4'b0, cmd_q.row_d.t};
			P_ROW_O:   byte_d = CH_ZERO + {4'b0, cmd_q.row_d.o};
			P_SEMI:    byte_d = CH_SEMI;
			P_COL_H:   byte_d = CH_ZERO + {6'b0, cmd_q.col_d.h};
			P_COL_T:   byte_d = CH_ZERO + {4'b0, cmd_q.col_d.t};
			P_COL_O:   byte_d = CH_ZERO + {4'b0, cmd_q.col_d.o};
			P_MV_H:    byte_d = CH_H;
			P_CL_ESC:  byte_d = CH_ESC;
			P_CL_LB:   byte_d = CH_LBRACK;
			P_CL_BANK: byte_d = cmd_q.color[3] ? CH_NINE : CH_THREE;
			P_CL_DIG:  byte_d = CH_ZERO + {5'b0, cmd_q.color[2:0]};
			P_CL_M:    byte_d = CH_M;
			P_GLYPH:   byte_d = cmd_q.glyph;
			P_RS_ESC:  byte_d = CH_ESC;
			P_RS_LB:   byte_d = CH_LBRACK;
			P_RS_ZERO: byte_d = CH_ZERO;
			P_RS_M:    byte_d = CH_M;
			default:   byte_d = 8'd0;
		endcase
	end

	// Request held while its bytes go out.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (emit) begin
			byte_q <= byte_d;
			last_q <= !nxt.found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			pos_q     <= P_MV_ESC;
			out_vld_q <= 1'b0;
		end else begin
			active_q <= active_d;
			pos_q    <= pos_d;
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/cde_checker.sv =====
// ---------------------------------------------------------------------------
// cde_checker
// Port-level checks of the encoder, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module cde_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast
);

	logic seen_q;

	// Remember whether any cell request was taken since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			seen_q <= 1'b1;
		end
	end

	// A stalled output byte holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output byte changed while stalled");

	// The store clearing pass keeps the input closed right after reset.
	a_clear_closed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_tready)
		else $error("input opened before the clearing pass");

	// No byte appears before any cell was accepted.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_q)
		else $error("output byte without any accepted cell");

endmodule

bind cell_diff_ansi_encoder cde_checker u_cde_checker (.*);

`default_nettype wire

// ===== tb/tb_cell_diff_ansi_encoder.sv =====
// ---------------------------------------------------------------------------
// tb_cell_diff_ansi_encoder
// Self-checking testbench for the dirty-cell terminal update encoder. A short
// table of directed cells comes first. A random part follows, built mostly
// from small raster frames with repeated and changed content. Every output
// byte is checked against a cycle-free model or a directed row's typed bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_cell_diff_ansi_encoder import cde_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RAND_CELLS   = 190;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int STORE_DEPTH  = MAX_ROWS_DEF * MAX_COLS_DEF;

	// One cell request, with an optional typed byte string for the directed
	// rows whose output can be read off directly.
	typedef struct packed {
		logic [5:0]   row;
		logic [6:0]   col;
		logic [7:0]   glyph;
		logic [3:0]   color;
		logic         fe;
		logic         typed;
		logic [4:0]   n;
		logic [159:0] txt;
	} cell_vec_t;

	// One byte of the terminal stream.
	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} term_byte_t;

	// Directed cells.
	localparam int DIR_ROWS = 21;
	localparam cell_vec_t DIR_TAB [DIR_ROWS] = '{
		'{0,  0,   "A",   1,  0, 1, 12, "\033[1;1H\033[31mA"},
		'{0,  1,   "B",   1,  0, 1, 1,  "B"},
		'{0,  2,   8'h00, 0,  0, 1, 0,  '0},
		'{0,  3,   "C",   15, 1, 1, 16, "\033[1;4H\033[97mC\033[0m"},
		'{63, 127, 8'hFF, 8,  0, 1, 15, "\033[64;128H\033[90m\377"},
		'{63, 127, 8'hFF, 8,  1, 1, 4,  "\033[0m"},
		'{5,  5,   8'h00, 0,  1, 1, 0,  '0},
		'{9,  98,  "x",   7,  0, 0, 0,  '0},
		'{9,  99,  "y",   7,  0, 0, 0,  '0},
		'{9,  100, "z",   3,  0, 0, 0,  '0},
		'{9,  0,   "q",   3,  0, 0, 0,  '0},
		'{9,  1,   8'h00, 0,  0, 0, 0,  '0},
		'{9,  2,   "w",   3,  0, 0, 0,  '0},
		'{10, 10,  8'h00, 5,  0, 0, 0,  '0},
		'{10, 11,  8'h80, 0,  1, 0, 0,  '0},
		'{0,  0,   "A",   1,  0, 0, 0,  '0},
		'{0,  1,   "Q",   1,  1, 0, 0,  '0},
		'{50, 110, "M",   12, 1, 0, 0,  '0},
		'{63, 127, 8'h00, 0,  1, 0, 0,  '0},
		'{42, 85,  8'h55, 10, 0, 0, 0,  '0},
		'{21, 42,  8'hAA, 5,  1, 0, 0,  '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	cell_vec_t cur_vec = '0;
	logic      calm = 1'b0;
	logic      hold_go = 1'b0;
	int        mismatches = 0;
	int        cycles = 0;

	// Model state: the shown frame plus run and color tracking.
	logic [7:0] scr_glyph [STORE_DEPTH];
	logic [3:0] scr_color [STORE_DEPTH];
	logic       in_run = 1'b0;
	logic [3:0] pen_color = '0;
	logic       pen_valid = 1'b0;
	logic       frame_dirty = 1'b0;
	logic [7:0] enc_bytes [$];

	// Last content sent to each cell, used only to build repeated cells.
	logic [7:0] sent_glyph [STORE_DEPTH];
	logic [3:0] sent_color [STORE_DEPTH];

	term_byte_t term_bytes [$];

	cell_diff_ansi_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			scr_glyph[i]  = '0;
			scr_color[i]  = '0;
			sent_glyph[i] = '0;
			sent_color[i] = '0;
		end
	end

	// Append a 1-based decimal number without leading zeros.
	function automatic void put_dec(input int v);
		if (v >= 100)
			enc_bytes.push_back(CH_ZERO + 8'((v / 100) % 10));
		if (v >= 10)
			enc_bytes.push_back(CH_ZERO + 8'((v / 10) % 10));
		enc_bytes.push_back(CH_ZERO + 8'(v % 10));
	endfunction

	// Work out the bytes one cell causes and update the shown frame.
	function automatic void encode_cell(input cell_vec_t c);
		int   idx;
		logic changed;
		idx = 0;
		changed = 1'b0;
		enc_bytes.delete();
		if (c.col == 0)
			in_run = 1'b0;
		if (int'(c.row) < MAX_ROWS_DEF && int'(c.col) < MAX_COLS_DEF) begin
			idx = int'(c.row) * MAX_COLS_DEF + int'(c.col);
			changed = (scr_glyph[idx] != c.glyph) || (scr_color[idx] != c.color);
		end
		if (changed) begin
			// Cursor move at the head of a run.
			if (!in_run) begin
				enc_bytes.push_back(CH_ESC);
				enc_bytes.push_back(CH_LBRACK);
				put_dec(int'(c.row) + 1);
				enc_bytes.push_back(CH_SEMI);
				put_dec(int'(c.col) + 1);
				enc_bytes.push_back(CH_H);
				in_run = 1'b1;
			end
			// Color escape only when the pen color changes.
			if (!pen_valid || pen_color != c.color) begin
				enc_bytes.push_back(CH_ESC);
				enc_bytes.push_back(CH_LBRACK);
				enc_bytes.push_back(c.color[3] ? CH_NINE : CH_THREE);
				enc_bytes.push_back(CH_ZERO + {5'b0, c.color[2:0]});
				enc_bytes.push_back(CH_M);
				pen_color = c.color;
				pen_valid = 1'b1;
			end
			enc_bytes.push_back(c.glyph);
			scr_glyph[idx] = c.glyph;
			scr_color[idx] = c.color;
			frame_dirty = 1'b1;
		end else begin
			in_run = 1'b0;
		end
		// Attribute reset closes a frame that sent anything.
		if (c.fe) begin
			if (frame_dirty) begin
				enc_bytes.push_back(CH_ESC);
				enc_bytes.push_back(CH_LBRACK);
				enc_bytes.push_back(CH_ZERO);
				enc_bytes.push_back(CH_M);
			end
			in_run = 1'b0;
			pen_valid = 1'b0;
			frame_dirty = 1'b0;
		end
	endfunction

	// Predict on every accepted cell and check every accepted byte.
	always @(posedge clk) begin : scoreboard
		cell_vec_t  c;
		term_byte_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				c = cur_vec;
				c.row   = s_tdata[5:0];
				c.col   = s_tdata[12:6];
				c.glyph = s_tdata[20:13];
				c.color = s_tdata[24:21];
				c.fe    = s_tlast;
				encode_cell(c);
				if (c.typed) begin
					enc_bytes.delete();
					for (int k = 0; k < int'(c.n); k++)
						enc_bytes.push_back(c.txt[8 * (int'(c.n) - 1 - k) +: 8]);
				end
				foreach (enc_bytes[k])
					term_bytes.push_back('{b: enc_bytes[k], last: (k == enc_bytes.size() - 1)});
			end
			if (m_tvalid && m_tready) begin
				if (term_bytes.size() == 0) begin
					$display("%0t: unexpected byte: expected none, got %02h last %0b",
						$time, m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = term_bytes.pop_front();
					if (m_tdata !== want.b) begin
						$display("%0t: out_byte mismatch: expected %02h, got %02h",
							$time, want.b, m_tdata);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last_of_item mismatch: expected %0b, got %0b",
							$time, want.last, m_tlast);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Output side: random backpressure, one long hold-off, a calm window.
	initial begin : sink_drive
		int  hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 36);
			end
		end
	end

	// Offer one cell request and wait until it is taken.
	task automatic push_cell(input cell_vec_t v);
		if (!calm && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, v.color, v.glyph, v.col, v.row};
		s_tlast  <= v.fe;
		cur_vec  <= v;
		sent_glyph[{v.row, v.col}] = v.glyph;
		sent_color[{v.row, v.col}] = v.color;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop offering and wait until every expected byte has come.
	task automatic drain_bytes();
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		do @(posedge clk); while (term_bytes.size() != 0);
	endtask

	// Main sequence.
	initial begin : stimulus
		cell_vec_t v;
		int        n_rand;
		int        len;
		int        pick;
		logic [3:0] prev_color;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int i = 0; i < DIR_ROWS; i++)
			push_cell(DIR_TAB[i]);
		drain_bytes();

		// Random part: mostly small frames, some stray cells.
		n_rand = 0;
		while (n_rand < RAND_CELLS) begin
			if ($urandom_range(99) < 12) begin
				v = '0;
				v.row   = 6'($urandom);
				v.col   = 7'($urandom);
				v.glyph = 8'($urandom);
				v.color = 4'($urandom);
				v.fe    = ($urandom_range(7) == 0);
				calm <= (n_rand >= 100 && n_rand < 150);
				if (n_rand == 40)
					hold_go <= 1'b1;
				push_cell(v);
				n_rand++;
			end else begin
				len = $urandom_range(1, 12);
				v = '0;
				v.row = ($urandom_range(99) < 80) ? 6'($urandom_range(0, 3))
					: 6'($urandom_range(60, 63));
				pick = $urandom_range(99);
				v.col = (pick < 20) ? 7'd0 : (pick < 70) ? 7'($urandom_range(0, 12))
					: 7'($urandom_range(90, 127));
				prev_color = 4'($urandom);
				for (int k = 0; k < len; k++) begin
					pick = $urandom_range(99);
					if (pick < 40) begin
						// Same content as the screen already shows.
						v.glyph = sent_glyph[{v.row, v.col}];
						v.color = sent_color[{v.row, v.col}];
					end else begin
						v.glyph = 8'($urandom);
						v.color = (pick < 70) ? prev_color : 4'($urandom);
					end
					prev_color = v.color;
					v.fe = (k == len - 1);
					calm <= (n_rand >= 100 && n_rand < 150);
					if (n_rand == 40)
						hold_go <= 1'b1;
					push_cell(v);
					n_rand++;
					// Next cell in raster order, now and then a jump to a new row.
					if (v.col == 7'd127 || $urandom_range(9) == 0) begin
						v.col = 7'd0;
						v.row = v.row + 6'd1;
					end else begin
						v.col = v.col + 7'd1;
					end
				end
			end
		end

		drain_bytes();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
